// File: hdl/fpr_pkg.sv
package fpr_pkg;

  // Table geometry
  localparam int FRAMES    = 4;
  localparam int PAGE_BITS = 16;
  localparam int FRAME_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W     = $clog2(FRAMES + 1);

  // Port field widths
  localparam int CFG_W      = 3;
  localparam int IN_PAGE_W  = 16;
  localparam int OUT_PAGE_W = 16;
  localparam int OUT_IDX_W  = 2;

  // Value of frames_in_use after reset
  localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = CFG_W'(4);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } fpr_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } fpr_cmd_t;

endpackage

// File: hdl/fpr_ctrl.sv
module fpr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output fpr_pkg::fpr_cmd_t cmd
);

  fpr_pkg::fpr_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fpr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fpr_pkg::ST_IDLE: begin
        if (start) state_nxt = fpr_pkg::ST_EXEC;
      end
      fpr_pkg::ST_EXEC: begin
        state_nxt = fpr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = fpr_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    busy     = 1'b0;
    cmd.load = 1'b0;
    cmd.exec = 1'b0;
    case (state_r)
      fpr_pkg::ST_IDLE: begin
        cmd.load = start;
      end
      fpr_pkg::ST_EXEC: begin
        busy     = 1'b1;
        cmd.exec = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // An accepted item is processed in the following cycle
  a_load_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.exec)
    else $error("accepted item not executed");

  // Never two lookups back to back
  a_exec_single: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> !cmd.exec)
    else $error("exec held for two cycles");

endmodule

// File: hdl/fpr_datapath.sv
module fpr_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  fpr_pkg::fpr_cmd_t                  cmd,
  input  logic [fpr_pkg::IN_PAGE_W-1:0]      in_page_number,
  input  logic                               cfg_we,
  input  logic [fpr_pkg::CFG_W-1:0]          cfg_data,
  output logic                               out_valid,
  output logic                               out_hit,
  output logic [fpr_pkg::OUT_IDX_W-1:0]      out_frame_index,
  output logic                               out_evicted_valid,
  output logic [fpr_pkg::OUT_PAGE_W-1:0]     out_evicted_page
);

  localparam int FRAMES  = fpr_pkg::FRAMES;
  localparam int FRAME_W = fpr_pkg::FRAME_W;
  localparam int CNT_W   = fpr_pkg::CNT_W;
  localparam int PB      = fpr_pkg::PAGE_BITS;

  logic [PB-1:0]                   page_r;
  logic [fpr_pkg::CFG_W-1:0]       frames_in_use_r;
  logic [PB-1:0]                   frame_page_r [FRAMES];
  logic [FRAMES-1:0]               frame_valid_r;
  logic [FRAME_W-1:0]              vptr_r, vptr_nxt;

  logic                            out_valid_r;
  logic                            out_hit_r;
  logic [fpr_pkg::OUT_IDX_W-1:0]   out_idx_r;
  logic                            out_ev_valid_r;
  logic [fpr_pkg::OUT_PAGE_W-1:0]  out_ev_page_r;

  logic [CNT_W-1:0]                n_act;
  logic                            hit_found, empty_found;
  logic [FRAME_W-1:0]              hit_slot, empty_slot, victim, slot;
  logic [CNT_W-1:0]                victim_inc;
  logic [PB-1:0]                   ev_page;

  // Active frame count: zero acts as one, saturate at the built count
  always_comb begin
    if (frames_in_use_r == '0) begin
      n_act = CNT_W'(1);
    end else if (int'(frames_in_use_r) > FRAMES) begin
      n_act = CNT_W'(FRAMES);
    end else begin
      n_act = CNT_W'(frames_in_use_r);
    end
  end

  // Parallel tag compare and empty search, lowest frame wins
  always_comb begin
    hit_found   = 1'b0;
    hit_slot    = '0;
    empty_found = 1'b0;
    empty_slot  = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (i < int'(n_act)) begin
        if (frame_valid_r[i] && frame_page_r[i] == page_r) begin
          hit_found = 1'b1;
          hit_slot  = FRAME_W'(i);
        end
        if (!frame_valid_r[i]) begin
          empty_found = 1'b1;
          empty_slot  = FRAME_W'(i);
        end
      end
    end
  end

  // Round-robin victim and its successor
  always_comb begin
    victim     = (CNT_W'(vptr_r) < n_act) ? vptr_r : '0;
    victim_inc = CNT_W'(victim) + CNT_W'(1);
    vptr_nxt   = (victim_inc >= n_act) ? '0 : FRAME_W'(victim_inc);
    ev_page    = frame_page_r[victim];
    if (hit_found) begin
      slot = hit_slot;
    end else if (empty_found) begin
      slot = empty_slot;
    end else begin
      slot = victim;
    end
  end

  // Control state: config, valid bits, pointer, strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= fpr_pkg::FRAMES_IN_USE_RST;
      frame_valid_r   <= '0;
      vptr_r          <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      out_valid_r <= cmd.exec;
      if (cfg_we) frames_in_use_r <= cfg_data;
      if (cmd.exec && !hit_found) begin
        frame_valid_r[slot] <= 1'b1;
        if (!empty_found) vptr_r <= vptr_nxt;
      end
    end
  end

  // Payload: latched page, frame table, result fields
  always_ff @(posedge clk) begin
    if (cmd.load) page_r <= PB'(in_page_number);
    if (cmd.exec) begin
      if (!hit_found) frame_page_r[slot] <= page_r;
      out_hit_r      <= hit_found;
      out_idx_r      <= fpr_pkg::OUT_IDX_W'(slot);
      out_ev_valid_r <= !hit_found && !empty_found;
      out_ev_page_r  <= (!hit_found && !empty_found) ?
                        fpr_pkg::OUT_PAGE_W'(ev_page) : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame_index   = out_idx_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_page  = out_ev_page_r;

  // Every lookup yields exactly one result strobe next cycle
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid)
    else $error("lookup produced no result");

  // A hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_evicted_valid)
    else $error("eviction reported on hit");

  // After a miss the chosen frame is valid
  a_fill_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && !hit_found |=> frame_valid_r[$past(slot)])
    else $error("filled frame not marked valid");

  // Victim pointer stays within the built table
  a_vptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(vptr_r) < FRAMES)
    else $error("victim pointer out of range");

endmodule

// File: hdl/fifo_page_replacement_core.sv
// FIFO page replacement core: four-frame fully associative table.
// The result strobe follows the start cycle: the page is latched, then the lookup/update result is registered.
// Start is ignored while busy; busy is high during the lookup cycle.
// The result strobe lasts one cycle; the receiver cannot stall it.
// Synchronous active-low reset empties all frames, clears the victim pointer
// and sets frames_in_use to 4; no clearing pass is needed.
module fifo_page_replacement_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [fpr_pkg::IN_PAGE_W-1:0]      in_page_number,
  output logic                               out_valid,
  output logic                               out_hit,
  output logic [fpr_pkg::OUT_IDX_W-1:0]      out_frame_index,
  output logic                               out_evicted_valid,
  output logic [fpr_pkg::OUT_PAGE_W-1:0]     out_evicted_page,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fpr_pkg::CFG_W-1:0]          cfg_frames_in_use
);

  fpr_pkg::fpr_cmd_t cmd;

  // Register port is always open
  assign cfg_ready = 1'b1;

  fpr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  fpr_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_page_number    (in_page_number),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_data          (cfg_frames_in_use),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page)
  );

endmodule
